>>> design/spc_pkg.sv
// Shared types and constants for the scanner pixel calibrator.
// Holds datapath command codes, curve constants and the log table generator.
package spc_pkg;

    localparam logic [1:0] MODE_LOG   = 2'd0;
    localparam logic [1:0] MODE_LIN_A = 2'd1;
    localparam logic [1:0] MODE_LIN_B = 2'd2;
    localparam logic [1:0] MODE_LIN_C = 2'd3;

    localparam logic [7:0] CFG_MODE = 8'd0;
    localparam logic [7:0] CFG_ROWS = 8'd1;
    localparam logic [7:0] CFG_COLS = 8'd2;

    localparam logic [34:0] LOG_P32   = 35'd19194514058;
    localparam logic [22:0] LOG_QL24  = 23'd4695773;
    localparam logic [34:0] LIN_A_C0  = 35'd16273631085;
    localparam logic [22:0] LIN_A_K   = 23'd4061665;
    localparam logic [34:0] LIN_B_C0  = 35'd17034016228;
    localparam logic [22:0] LIN_B_K   = 23'd4254415;
    localparam logic [18:0] LIN_C_NUM = 19'd409699;
    localparam logic [16:0] LIN_C_DEN = 17'd100901;

    // 2^32 = QA * DEN + QB; RECIP = ceil(2^48 / DEN), exact for products below 2^31
    localparam logic [15:0] LIN_C_QA    = 16'((64'd1 << 32) / 64'(LIN_C_DEN));
    localparam logic [13:0] LIN_C_QB    = 14'((64'd1 << 32) % 64'(LIN_C_DEN));
    localparam logic [31:0] LIN_C_RECIP =
        32'(((64'd1 << 48) + 64'(LIN_C_DEN) - 64'd1) / 64'(LIN_C_DEN));

    localparam logic [15:0] LOG_R_MIN   = 16'd4;
    localparam logic [15:0] LOG_R_MAX   = 16'd64064;
    localparam logic [15:0] LIN_A_R_MAX = 16'd4006;
    localparam logic [15:0] LIN_B_R_MAX = 16'd4003;
    localparam logic [15:0] LIN_C_R_MIN = 16'd61;
    localparam logic [15:0] LIN_C_R_MAX = 16'd4097;

    localparam int unsigned DIV_STEPS = 3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HOLD,
        OP_LOAD,
        OP_NORM,
        OP_LOOK,
        OP_INTERP,
        OP_LOG,
        OP_MUL,
        OP_DIFF,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ROUND,
        OP_SCALE,
        OP_SQUARE,
        OP_GREY,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
        logic pixel;
    } cmd_t;

    // log2 of x / 2^30 in Q.24 by repeated squaring; elaboration use only
    function automatic logic [24:0] log_entry(input logic [63:0] x_in);
        logic [63:0] x;
        logic [31:0] res;
        x   = x_in;
        res = '0;
        if (x >= 64'h8000_0000) begin
            res = 32'h0100_0000;
            x   = x >> 1;
        end
        for (int b = 23; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= 64'h8000_0000) begin
                x      = x >> 1;
                res[b] = 1'b1;
            end
        end
        return res[24:0];
    endfunction

endpackage

>>> design/scanner_pixel_calibrator_core.sv
// A high byte is taken with no result; a last high byte goes straight to EMIT and raises its
// result. A low byte steps through NORM, LOOK, INTERP, LOG, MUL, DIFF for the log curve, MUL,
// DIFF for linear A and B, DIV_START and a three-step reciprocal divide for linear C, then
// ROUND, SCALE, SQUARE, GREY, EMIT. One pixel in flight; EMIT waits while an earlier result
// waits for m_ready. Synchronous active-low reset to reset values, except the datapath pipeline
// and output registers; no clearing pass. Depends on spc_pkg, spc_ctrl, spc_datapath.
module scanner_pixel_calibrator_core #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_grey_level,
    output logic        m_value_error,
    output logic        m_end_of_image,
    output logic        m_size_matches,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import spc_pkg::*;

    logic [1:0]  mode_reg;
    logic [15:0] rows_reg;
    logic [15:0] cols_reg;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LOG;
            rows_reg <= 16'd1;
            cols_reg <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE: mode_reg <= cfg_data[1:0];
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    spc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .mode        (mode_reg),
        .cmd         (cmd)
    );

    spc_datapath #(
        .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .byte_value   (s_byte_value),
        .mode         (mode_reg),
        .image_rows   (rows_reg),
        .image_cols   (cols_reg),
        .grey_level   (m_grey_level),
        .value_error  (m_value_error),
        .end_of_image (m_end_of_image),
        .size_matches (m_size_matches)
    );

    a_size_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_size_matches) |-> m_end_of_image)
        else $error("size_matches set on a non-final item");

    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised without a processing step");

    a_busy_after_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && cmd.op == OP_LOAD) |=> !s_ready)
        else $error("input taken while a pixel is in flight");

endmodule

>>> design/spc_ctrl.sv
// Sequencer for the scanner pixel calibrator: handshakes, byte pairing,
// and the step order per curve. Depends on spc_pkg.
module spc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_last_byte,
    output logic          m_valid,
    input  logic          m_ready,
    input  logic [1:0]    mode,
    output spc_pkg::cmd_t cmd
);
    import spc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOOK,
        ST_INTERP,
        ST_LOG,
        ST_MUL,
        ST_DIFF,
        ST_DIV_START,
        ST_DIV,
        ST_ROUND,
        ST_SCALE,
        ST_SQUARE,
        ST_GREY,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic        phase_reg;
    logic        last_reg;
    logic        pixel_reg;
    logic        m_valid_reg;
    logic [5:0]  div_cnt_reg;
    logic        accept;
    logic        slot_free;
    op_t         op;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                if (!accept) op = OP_NONE;
                else if (phase_reg) op = OP_LOAD;
                else if (!s_last_byte) op = OP_HOLD;
                else op = OP_NONE;
            end
            ST_NORM:      op = OP_NORM;
            ST_LOOK:      op = OP_LOOK;
            ST_INTERP:    op = OP_INTERP;
            ST_LOG:       op = OP_LOG;
            ST_MUL:       op = OP_MUL;
            ST_DIFF:      op = OP_DIFF;
            ST_DIV_START: op = OP_DIV_START;
            ST_DIV:       op = OP_DIV_STEP;
            ST_ROUND:     op = OP_ROUND;
            ST_SCALE:     op = OP_SCALE;
            ST_SQUARE:    op = OP_SQUARE;
            ST_GREY:      op = OP_GREY;
            ST_EMIT:      op = slot_free ? OP_EMIT : OP_NONE;
            default:      op = OP_NONE;
        endcase
    end

    assign cmd = '{op: op, last: last_reg, pixel: pixel_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            last_reg    <= 1'b0;
            pixel_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            if (m_valid_reg && m_ready && !(state_reg == ST_EMIT && slot_free))
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        last_reg  <= s_last_byte;
                        pixel_reg <= phase_reg;
                        if (phase_reg) begin
                            phase_reg <= 1'b0;
                            unique case (mode)
                                MODE_LOG:   state_reg <= ST_NORM;
                                MODE_LIN_C: state_reg <= ST_DIV_START;
                                default:    state_reg <= ST_MUL;
                            endcase
                        end else if (s_last_byte) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            phase_reg <= 1'b1;
                        end
                    end
                end
                ST_NORM:      state_reg <= ST_LOOK;
                ST_LOOK:      state_reg <= ST_INTERP;
                ST_INTERP:    state_reg <= ST_LOG;
                ST_LOG:       state_reg <= ST_MUL;
                ST_MUL:       state_reg <= ST_DIFF;
                ST_DIFF:      state_reg <= ST_ROUND;
                ST_DIV_START: begin
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'(DIV_STEPS - 1)) state_reg <= ST_ROUND;
                end
                ST_ROUND:     state_reg <= ST_SCALE;
                ST_SCALE:     state_reg <= ST_SQUARE;
                ST_SQUARE:    state_reg <= ST_GREY;
                ST_GREY:      state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> design/spc_datapath.sv
// Arithmetic for the scanner pixel calibrator: clamp, log table, curves,
// reciprocal divider, companding and the result registers. Depends on spc_pkg.
module spc_datapath #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  spc_pkg::cmd_t cmd,
    input  logic [7:0]    byte_value,
    input  logic [1:0]    mode,
    input  logic [15:0]   image_rows,
    input  logic [15:0]   image_cols,
    output logic [15:0]   grey_level,
    output logic          value_error,
    output logic          end_of_image,
    output logic          size_matches
);
    import spc_pkg::*;

    localparam int IW = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] IDX_MAX = IW'(LOG_TABLE_ENTRIES - 1);

    logic [24:0] log_rom [0:LOG_TABLE_ENTRIES];

    for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
        localparam logic [63:0] X0 =
            ((64'(LOG_TABLE_ENTRIES) + 64'(g)) << 30) / 64'(LOG_TABLE_ENTRIES);
        assign log_rom[g] = log_entry(X0);
    end

    logic [7:0]    held_reg;
    logic [31:0]   count_reg;
    logic          err_reg;
    logic [31:0]   size_prod_reg;
    logic [1:0]    mode_reg;
    logic          zero_reg;
    logic [15:0]   r_reg;
    logic [3:0]    e_reg;
    logic [IW-1:0] idx_reg;
    logic [14:0]   rem_reg;
    logic [24:0]   lo_reg;
    logic [24:0]   hi_reg;
    logic [39:0]   dprod_reg;
    logic [28:0]   log_reg;
    logic [51:0]   mprod_reg;
    logic [34:0]   d_reg;
    logic [1:0]    dq_reg;
    logic [16:0]   dr_reg;
    logic [32:0]   dhi_reg;
    logic [30:0]   dlo_reg;
    logic [62:0]   drec_reg;
    logic [34:0]   dv_reg;
    logic [17:0]   d16_reg;
    logic [15:0]   v_reg;
    logic [31:0]   sq_reg;
    logic [15:0]   grey_reg;
    logic [15:0]   grey_out_reg;
    logic          err_out_reg;
    logic          eoi_out_reg;
    logic          size_out_reg;

    logic [15:0]        raw;
    logic [15:0]        rc;
    logic [3:0]         e_calc;
    logic [15:0]        m_norm;
    logic [14+IW:0]     pos;
    logic [IW-1:0]      idx_calc;
    logic [IW-1:0]      idx_next;
    logic [24:0]        lo_calc;
    logic [24:0]        hi_calc;
    logic [34:0]        sub_val;
    logic [34:0]        c_val;
    logic [36:0]        diff;
    logic [19:0]        r100;
    logic [18:0]        n_val;
    logic [1:0]         dq_calc;
    logic [18:0]        dq_sub;
    logic [34:0]        d_src;
    logic [35:0]        rsum;
    logic [19:0]        d16_full;
    logic [33:0]        sprod;
    logic [16:0]        csum;
    logic [15:0]        grey_calc;

    assign raw = {held_reg, byte_value};

    always_comb begin
        rc = raw;
        unique case (mode)
            MODE_LOG: begin
                if (raw > LOG_R_MAX) rc = LOG_R_MAX;
                else if (raw < LOG_R_MIN) rc = LOG_R_MIN;
            end
            MODE_LIN_A: if (raw > LIN_A_R_MAX) rc = LIN_A_R_MAX;
            MODE_LIN_B: if (raw > LIN_B_R_MAX) rc = LIN_B_R_MAX;
            MODE_LIN_C: begin
                if (raw > LIN_C_R_MAX) rc = LIN_C_R_MAX;
                else if (raw < LIN_C_R_MIN) rc = LIN_C_R_MIN;
            end
            default: rc = raw;
        endcase
    end

    always_comb begin
        e_calc = '0;
        for (int k = 0; k < 16; k++) begin
            if (r_reg[k]) e_calc = 4'(k);
        end
    end

    assign m_norm   = r_reg << (4'd15 - e_calc);
    assign pos      = (15+IW)'(m_norm[14:0]) * (15+IW)'(LOG_TABLE_ENTRIES);
    assign idx_calc = (pos[14+IW:15] > IDX_MAX) ? IDX_MAX : pos[14+IW:15];
    assign idx_next = idx_reg + IW'(1);
    assign lo_calc  = log_rom[idx_reg];
    assign hi_calc  = (log_rom[idx_next] < lo_calc) ? lo_calc : log_rom[idx_next];

    always_comb begin
        unique case (mode_reg)
            MODE_LOG: begin
                c_val   = LOG_P32;
                sub_val = mprod_reg[50:16];
            end
            MODE_LIN_A: begin
                c_val   = LIN_A_C0;
                sub_val = mprod_reg[34:0];
            end
            default: begin
                c_val   = LIN_B_C0;
                sub_val = mprod_reg[34:0];
            end
        endcase
    end

    assign diff  = {2'b00, c_val} - {2'b00, sub_val};
    assign r100  = 20'(r_reg) * 20'd100;
    assign n_val = (r100 >= 20'(LIN_C_NUM)) ? 19'd0 : 19'(20'(LIN_C_NUM) - r100);

    // clamped r keeps the numerator below four times the divisor
    always_comb begin
        if (n_val >= 19'(3 * LIN_C_DEN)) begin
            dq_calc = 2'd3;
            dq_sub  = 19'(3 * LIN_C_DEN);
        end else if (n_val >= 19'(2 * LIN_C_DEN)) begin
            dq_calc = 2'd2;
            dq_sub  = 19'(2 * LIN_C_DEN);
        end else if (n_val >= 19'(LIN_C_DEN)) begin
            dq_calc = 2'd1;
            dq_sub  = 19'(LIN_C_DEN);
        end else begin
            dq_calc = 2'd0;
            dq_sub  = 19'd0;
        end
    end

    assign d_src    = (mode_reg == MODE_LIN_C) ? dv_reg : d_reg;
    assign rsum     = {1'b0, d_src} + 36'd32768;
    assign d16_full = rsum[35:16];
    assign sprod    = 34'(d16_reg) * 34'd65535;

    always_comb begin
        csum = {1'b0, sq_reg[31:16]} + {1'b0, sq_reg[15:0]};
        if (csum >= 17'd131070) grey_calc = sq_reg[31:16] + 16'd2;
        else if (csum >= 17'd65535) grey_calc = sq_reg[31:16] + 16'd1;
        else grey_calc = sq_reg[31:16];
    end

    always_ff @(posedge aclk) begin
        size_prod_reg <= 32'(image_rows) * 32'(image_cols);
        unique case (cmd.op)
            OP_LOAD: begin
                mode_reg <= mode;
                zero_reg <= (raw == 16'd0);
                r_reg    <= rc;
            end
            OP_NORM: begin
                e_reg   <= e_calc;
                idx_reg <= idx_calc;
                rem_reg <= pos[14:0];
            end
            OP_LOOK: begin
                lo_reg <= lo_calc;
                hi_reg <= hi_calc;
            end
            OP_INTERP: dprod_reg <= 40'(hi_reg - lo_reg) * 40'(rem_reg);
            OP_LOG: begin
                log_reg <= {e_reg, 24'd0} + 29'(lo_reg)
                           + 29'((dprod_reg + 40'd16384) >> 15);
            end
            OP_MUL: begin
                unique case (mode_reg)
                    MODE_LOG:   mprod_reg <= 52'(LOG_QL24) * 52'(log_reg);
                    MODE_LIN_A: mprod_reg <= 52'(LIN_A_K) * 52'(r_reg);
                    default:    mprod_reg <= 52'(LIN_B_K) * 52'(r_reg);
                endcase
            end
            OP_DIFF: begin
                if ((mode_reg == MODE_LOG && zero_reg) || diff[36]) d_reg <= '0;
                else d_reg <= diff[34:0];
            end
            OP_DIV_START: begin
                dq_reg <= dq_calc;
                dr_reg <= 17'(n_val - dq_sub);
            end
            // three-stage pipe: remainder products, reciprocal product, sum
            OP_DIV_STEP: begin
                dhi_reg  <= 33'(dr_reg) * 33'(LIN_C_QA);
                dlo_reg  <= 31'(dr_reg) * 31'(LIN_C_QB);
                drec_reg <= 63'(dlo_reg) * 63'(LIN_C_RECIP);
                dv_reg   <= 35'({dq_reg, 32'd0}) + 35'(dhi_reg) + 35'(drec_reg[62:48]);
            end
            OP_ROUND: begin
                if (d16_full >= 20'h40000) d16_reg <= 18'h3FFFF;
                else d16_reg <= d16_full[17:0];
            end
            OP_SCALE:  v_reg <= 16'hFFFF - sprod[33:18];
            OP_SQUARE: sq_reg <= 32'(v_reg) * 32'(v_reg);
            OP_GREY:   grey_reg <= grey_calc;
            OP_EMIT: begin
                grey_out_reg <= cmd.pixel ? grey_reg : 16'd0;
                err_out_reg  <= err_reg;
                eoi_out_reg  <= cmd.last;
                size_out_reg <= cmd.last && (count_reg == size_prod_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            unique case (cmd.op)
                OP_HOLD: held_reg <= byte_value;
                OP_LOAD: count_reg <= count_reg + 32'd1;
                OP_ROUND: if (d16_full >= 20'h40000) err_reg <= 1'b1;
                OP_EMIT: begin
                    if (cmd.last) begin
                        held_reg  <= '0;
                        count_reg <= '0;
                        err_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign grey_level   = grey_out_reg;
    assign value_error  = err_out_reg;
    assign end_of_image = eoi_out_reg;
    assign size_matches = size_out_reg;

endmodule
